// ===== hw/rtl/ifcp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ifcp_pkg
// Types, byte codes and the color palette of the IRC format code parser.
// ----------------------------------------------------------------------------
package ifcp_pkg;

    // Formatting bytes
    localparam logic [7:0] BYTE_BOLD      = 8'h02;
    localparam logic [7:0] BYTE_COLOR     = 8'h03;
    localparam logic [7:0] BYTE_PLAIN     = 8'h0F;
    localparam logic [7:0] BYTE_UNDERLINE = 8'h1F;
    localparam logic [7:0] BYTE_COMMA     = 8'h2C;
    localparam logic [7:0] BYTE_DIGIT_0   = 8'h30;
    localparam logic [7:0] BYTE_DIGIT_9   = 8'h39;

    // Default colors
    localparam logic [15:0] CLR_WHITE = 16'hFFFF;
    localparam logic [15:0] CLR_BLACK = 16'h0000;

    localparam int unsigned NUM_COLORS = 99;

    // Parse phase of a color code
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CTRL  = 3'd1,
        PH_FG1   = 3'd2,
        PH_FG2   = 3'd3,
        PH_COMMA = 3'd4,
        PH_BG1   = 3'd5
    } t_phase;

    // Parser state carried from one item to the next
    typedef struct packed {
        t_phase      phase;
        logic [15:0] fore;
        logic [15:0] back;
        logic        bold;
        logic        underline;
        logic [3:0]  first_digit;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:       PH_IDLE,
        fore:        CLR_WHITE,
        back:        CLR_BLACK,
        bold:        1'b0,
        underline:   1'b0,
        first_digit: 4'd0
    };

    // Fixed 99-entry RGB565 palette
    localparam logic [15:0] COLOR_TABLE [0:NUM_COLORS-1] = '{
        16'hFFFF, 16'h0000, 16'h0010, 16'h07E0, 16'hF800, 16'h8000, 16'h8010, 16'hFD20,
        16'hFFE0, 16'h9772, 16'h07FF, 16'hE7FF, 16'h001F, 16'hFE19, 16'h8410, 16'hD69A,
        16'h4000, 16'h4100, 16'h4220, 16'h3220, 16'h0220, 16'h0225, 16'h0228, 16'h0128,
        16'h0008, 16'h2808, 16'h4008, 16'h4005, 16'h7000, 16'h71C0, 16'h73A0, 16'h53A0,
        16'h03A0, 16'h03A9, 16'h03AE, 16'h020E, 16'h000E, 16'h480E, 16'h700E, 16'h7008,
        16'hB000, 16'hB300, 16'hB5A0, 16'h7DA0, 16'h05A0, 16'h05AE, 16'h05B6, 16'h0316,
        16'h0016, 16'h7016, 16'hB016, 16'hB00D, 16'hF800, 16'hFC60, 16'hFFE0, 16'hB7E0,
        16'h07E0, 16'h07F4, 16'h07FF, 16'h047F, 16'h001F, 16'hA01F, 16'hF81F, 16'hF813,
        16'hFACB, 16'hFDAB, 16'hFFEE, 16'hCFEC, 16'h6FED, 16'h67F9, 16'h6FFF, 16'h5DBF,
        16'h5ADF, 16'hC2DF, 16'hFB3F, 16'hFAD7, 16'hFCF3, 16'hFE93, 16'hFFF3, 16'hE7F3,
        16'h9FF3, 16'h9FFB, 16'h9FFF, 16'h9E9F, 16'h9CFF, 16'hDCFF, 16'hFCFF, 16'hFCBA,
        16'h0000, 16'h1082, 16'h2945, 16'h31A6, 16'h4A69, 16'h632C, 16'h8410, 16'h9CF3,
        16'hBDF7, 16'hE71C, 16'hFFFF
    };

    // Look up a color code; codes past the palette give white
    function automatic logic [15:0] color_of(input logic [6:0] code);
        logic [15:0] clr;
        if (code < 7'(NUM_COLORS)) begin
            clr = COLOR_TABLE[code];
        end else begin
            clr = CLR_WHITE;
        end
        return clr;
    endfunction

endpackage : ifcp_pkg
`default_nettype wire

// ===== hw/rtl/ifcp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ifcp_in_if / ifcp_out_if
// Valid/ready channels for message bytes in and formatted bytes out.
// ----------------------------------------------------------------------------
interface ifcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       first_of_message;

    modport source (output valid, byte_value, first_of_message, input ready);
    modport sink   (input valid, byte_value, first_of_message, output ready);
endinterface : ifcp_in_if

interface ifcp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_out;
    logic        visible;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic        bold_on;
    logic        underline_on;

    modport source (output valid, char_out, visible, fg_color, bg_color, bold_on,
                    underline_on, input ready);
    modport sink   (input valid, char_out, visible, fg_color, bg_color, bold_on,
                    underline_on, output ready);
endinterface : ifcp_out_if
`default_nettype wire

// ===== hw/rtl/ifcp_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ifcp_step
// Next parser state and visibility for one byte, given the current state.
// ----------------------------------------------------------------------------
module ifcp_step
    import ifcp_pkg::*;
(
    input  wire t_state     i_state,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_first,
    output t_state          o_state,
    output logic            o_visible
);

    t_state     s_cur;
    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] code_two;
    logic       as_text;

    // Decode digit and the two-digit code
    always_comb begin
        is_digit = (i_byte >= BYTE_DIGIT_0) && (i_byte <= BYTE_DIGIT_9);
        digit    = is_digit ? 4'(i_byte - BYTE_DIGIT_0) : 4'd0;
        code_two = {s_cur.first_digit, 3'b000} + {2'b00, s_cur.first_digit, 1'b0}
                 + {3'b000, digit};
    end

    // Start of message clears state before this byte
    assign s_cur = i_first ? STATE_RESET : i_state;

    // Advance the color code phase, fall back to text handling
    always_comb begin
        o_state   = s_cur;
        o_visible = 1'b0;
        as_text   = 1'b0;
        unique case (s_cur.phase)
            PH_CTRL: begin
                if (is_digit) begin
                    o_state.first_digit = digit;
                    o_state.fore        = color_of({3'b000, digit});
                    o_state.phase       = PH_FG1;
                end else if (i_byte == BYTE_COMMA) begin
                    o_state.phase = PH_COMMA;
                end else begin
                    as_text = 1'b1;
                end
            end
            PH_FG1: begin
                if (is_digit) begin
                    o_state.fore  = color_of(code_two);
                    o_state.phase = PH_FG2;
                end else if (i_byte == BYTE_COMMA) begin
                    o_state.phase = PH_COMMA;
                end else begin
                    as_text = 1'b1;
                end
            end
            PH_FG2: begin
                if (i_byte == BYTE_COMMA) begin
                    o_state.phase = PH_COMMA;
                end else begin
                    as_text = 1'b1;
                end
            end
            PH_COMMA: begin
                if (is_digit) begin
                    o_state.first_digit = digit;
                    o_state.back        = color_of({3'b000, digit});
                    o_state.phase       = PH_BG1;
                end else begin
                    as_text = 1'b1;
                end
            end
            PH_BG1: begin
                if (is_digit) begin
                    o_state.back  = color_of(code_two);
                    o_state.phase = PH_IDLE;
                end else begin
                    as_text = 1'b1;
                end
            end
            default: begin
                as_text = 1'b1;
            end
        endcase

        // Ordinary byte handling; state is untouched on this path so far
        if (as_text) begin
            o_state.phase = PH_IDLE;
            unique case (i_byte)
                BYTE_BOLD: begin
                    o_state.bold = ~s_cur.bold;
                end
                BYTE_UNDERLINE: begin
                    o_state.underline = ~s_cur.underline;
                end
                BYTE_PLAIN: begin
                    o_state.fore      = CLR_WHITE;
                    o_state.back      = CLR_BLACK;
                    o_state.bold      = 1'b0;
                    o_state.underline = 1'b0;
                end
                BYTE_COLOR: begin
                    o_state.fore  = CLR_WHITE;
                    o_state.back  = CLR_BLACK;
                    o_state.phase = PH_CTRL;
                end
                default: begin
                    o_visible = 1'b1;
                end
            endcase
        end
    end

endmodule : ifcp_step
`default_nettype wire

// ===== hw/rtl/irc_format_code_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// irc_format_code_parser
// IRC formatting-code parser: one result item per message byte.
// ----------------------------------------------------------------------------
// Each accepted byte gives one item with the byte echoed, a visible flag and
// the RGB565 colors, bold and underline in force after that byte. The block
// sustains one item per cycle unless the output stalls; each byte passes
// through the input register and then the result register. The parser state
// is updated in the same cycle the byte moves into the result register, so
// each byte sees the state left by the one before it. A stalled output holds
// its item while one further byte waits in the input register.
// ----------------------------------------------------------------------------
module irc_format_code_parser
    import ifcp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ifcp_in_if.sink     i_in,
    ifcp_out_if.source  o_out
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_first;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_visible;
    logic [15:0] r_out_fg;
    logic [15:0] r_out_bg;
    logic        r_out_bold;
    logic        r_out_ul;
    t_state      r_state;
    t_state      n_state;
    logic        n_visible;
    logic        advance;
    logic        take_in;

    // Handshake: result register frees when empty or taken
    assign advance    = ~r_out_valid | o_out.ready;
    assign i_in.ready = ~r_in_valid | advance;
    assign take_in    = i_in.valid & i_in.ready;

    ifcp_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .i_first   (r_in_first),
        .o_state   (n_state),
        .o_visible (n_visible)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (take_in) begin
            r_in_byte  <= i_in.byte_value;
            r_in_first <= i_in.first_of_message;
        end
    end

    // Parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_out_char    <= r_in_byte;
            r_out_visible <= n_visible;
            r_out_fg      <= n_state.fore;
            r_out_bg      <= n_state.back;
            r_out_bold    <= n_state.bold;
            r_out_ul      <= n_state.underline;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.char_out     = r_out_char;
    assign o_out.visible      = r_out_visible;
    assign o_out.fg_color     = r_out_fg;
    assign o_out.bg_color     = r_out_bg;
    assign o_out.bold_on      = r_out_bold;
    assign o_out.underline_on = r_out_ul;

endmodule : irc_format_code_parser
`default_nettype wire

// ===== hw/rtl/ifcp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ifcp_checker
// Port-level checks of the format code parser, bound to the top level.
// ----------------------------------------------------------------------------
module ifcp_checker
    import ifcp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_char_out,
    input wire logic        i_visible,
    input wire logic [15:0] i_fg_color,
    input wire logic [15:0] i_bg_color,
    input wire logic        i_bold_on,
    input wire logic        i_underline_on
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Hold a stalled item
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_char_out)
            && $stable(i_fg_color) && $stable(i_bg_color))
        else $error("stalled item changed");

    // Formatting bytes are never drawn
    a_codes_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_visible |-> i_char_out != BYTE_BOLD
            && i_char_out != BYTE_UNDERLINE && i_char_out != BYTE_PLAIN
            && i_char_out != BYTE_COLOR)
        else $error("formatting byte marked visible");

    // Plain byte clears every attribute
    a_plain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_char_out == BYTE_PLAIN |-> i_fg_color == CLR_WHITE
            && i_bg_color == CLR_BLACK && !i_bold_on && !i_underline_on)
        else $error("plain byte left attributes set");

    // Color byte restores white on black
    a_color_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_char_out == BYTE_COLOR |-> i_fg_color == CLR_WHITE
            && i_bg_color == CLR_BLACK)
        else $error("color byte did not restore default colors");

endmodule : ifcp_checker

bind irc_format_code_parser ifcp_checker u_ifcp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_char_out     (o_out.char_out),
    .i_visible      (o_out.visible),
    .i_fg_color     (o_out.fg_color),
    .i_bg_color     (o_out.bg_color),
    .i_bold_on      (o_out.bold_on),
    .i_underline_on (o_out.underline_on)
);
`default_nettype wire
